// ===== src/icp_pkg.sv =====
package icp_pkg;

    localparam int DEFAULT_STACK_DEPTH = 16;
    localparam int CMD_QUEUE_DEPTH = 4;

    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;

    typedef enum logic [2:0] {
        OPC_LPAREN = 3'd0,
        OPC_PLUS   = 3'd1,
        OPC_MINUS  = 3'd2,
        OPC_MUL    = 3'd3,
        OPC_DIV    = 3'd4
    } op_code_t;

    typedef enum logic [1:0] {
        TOK_NONE   = 2'd0,
        TOK_NUMBER = 2'd1,
        TOK_NAME   = 2'd2
    } tok_mode_t;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_ECHO,
        CMD_OPEN,
        CMD_CLOSE,
        CMD_OP,
        CMD_FLUSH
    } cmd_kind_t;

    typedef struct packed {
        logic       close_tok;
        cmd_kind_t  kind;
        op_code_t   code;
        logic [7:0] ch;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LEAD,
        ST_EXEC,
        ST_SPACE,
        ST_DONE
    } back_state_t;

    function automatic logic [7:0] code_char(input op_code_t code);
        logic [7:0] c;
        unique case (code)
            OPC_LPAREN: c = CH_LPAREN;
            OPC_PLUS:   c = CH_PLUS;
            OPC_MINUS:  c = CH_MINUS;
            OPC_MUL:    c = CH_STAR;
            OPC_DIV:    c = CH_SLASH;
            default:    c = CH_LPAREN;
        endcase
        return c;
    endfunction

    function automatic logic [1:0] op_rank(input op_code_t code);
        logic [1:0] r;
        if (code >= OPC_MUL) begin
            r = 2'd2;
        end else if (code >= OPC_PLUS) begin
            r = 2'd1;
        end else begin
            r = 2'd0;
        end
        return r;
    endfunction

endpackage

// ===== src/icp_front.sv =====
module icp_front
    import icp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] in_byte,
    input  logic       in_end,
    input  logic       accept,
    output logic       cmd_valid,
    output cmd_t       cmd
);

    tok_mode_t mode_reg;
    tok_mode_t mode_next;

    logic is_digit;
    logic is_alpha;
    logic is_space;
    logic cont;
    cmd_kind_t sym_kind;
    op_code_t sym_code;

    assign is_digit = (in_byte >= 8'h30) && (in_byte <= 8'h39);
    assign is_alpha = ((in_byte >= 8'h61) && (in_byte <= 8'h7A)) ||
                      ((in_byte >= 8'h41) && (in_byte <= 8'h5A));
    assign is_space = (in_byte == CH_SPACE) || (in_byte == CH_TAB) || (in_byte == CH_VT) ||
                      (in_byte == CH_FF) || (in_byte == CH_CR);

    always_comb
    begin
        sym_kind = CMD_NONE;
        sym_code = OPC_LPAREN;
        priority if (in_byte == CH_NL) begin
            sym_kind = CMD_FLUSH;
        end else if (in_byte == CH_LPAREN) begin
            sym_kind = CMD_OPEN;
        end else if (in_byte == CH_RPAREN) begin
            sym_kind = CMD_CLOSE;
        end else if (in_byte == CH_PLUS) begin
            sym_kind = CMD_OP;
            sym_code = OPC_PLUS;
        end else if (in_byte == CH_MINUS) begin
            sym_kind = CMD_OP;
            sym_code = OPC_MINUS;
        end else if (in_byte == CH_STAR) begin
            sym_kind = CMD_OP;
            sym_code = OPC_MUL;
        end else if (in_byte == CH_SLASH) begin
            sym_kind = CMD_OP;
            sym_code = OPC_DIV;
        end else begin
            sym_kind = CMD_NONE;
        end
    end

    always_comb
    begin
        if (mode_reg == TOK_NUMBER) begin
            cont = is_digit || (in_byte == CH_DOT);
        end else begin
            cont = is_alpha || is_digit || (in_byte == CH_UNDER);
        end
    end

    always_comb
    begin
        cmd.close_tok = 1'b0;
        cmd.kind      = CMD_NONE;
        cmd.code      = sym_code;
        cmd.ch        = in_byte;
        mode_next     = TOK_NONE;
        if (in_end) begin
            cmd.close_tok = (mode_reg == TOK_NUMBER) || (mode_reg == TOK_NAME);
            cmd.kind      = CMD_FLUSH;
        end else if ((mode_reg == TOK_NUMBER) || (mode_reg == TOK_NAME)) begin
            if (cont) begin
                cmd.kind  = CMD_ECHO;
                mode_next = mode_reg;
            end else begin
                cmd.close_tok = 1'b1;
                cmd.kind      = sym_kind;
            end
        end else if (is_space) begin
            cmd.kind = CMD_NONE;
        end else if (is_digit || (in_byte == CH_DOT)) begin
            cmd.kind  = CMD_ECHO;
            mode_next = TOK_NUMBER;
        end else if (is_alpha || (in_byte == CH_UNDER)) begin
            cmd.kind  = CMD_ECHO;
            mode_next = TOK_NAME;
        end else begin
            cmd.kind = sym_kind;
        end
    end

    assign cmd_valid = accept && (cmd.close_tok || (cmd.kind != CMD_NONE));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg <= TOK_NONE;
        end else if (accept) begin
            mode_reg <= mode_next;
        end
    end

endmodule

// ===== src/icp_queue.sv =====
module icp_queue
    import icp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  cmd_t wr_cmd,
    output logic full,
    output logic rd_valid,
    input  logic rd_en,
    output cmd_t rd_cmd
);

    localparam int PW = $clog2(CMD_QUEUE_DEPTH);

    cmd_t            mem_reg [CMD_QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   rd_ptr_reg;
    logic [PW:0]     count_reg;
    logic [PW:0]     count_next;

    assign full     = count_reg == (PW+1)'(CMD_QUEUE_DEPTH);
    assign rd_valid = count_reg != '0;
    assign rd_cmd   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (wr_en && !(rd_en && rd_valid)) begin
            count_next = count_reg + 1'b1;
        end else if (!wr_en && rd_en && rd_valid) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en) begin
            mem_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (wr_en) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (rd_en && rd_valid) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

endmodule

// ===== src/icp_back.sv =====
module icp_back
    import icp_pkg::*;
#(
    parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cmd_valid,
    input  cmd_t       cmd,
    output logic       cmd_pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       out_last
);

    localparam int TW = $clog2(STACK_DEPTH + 1);
    localparam int IW = $clog2(STACK_DEPTH);

    back_state_t state_reg;
    back_state_t state_next;
    cmd_t        cmd_reg;
    cmd_t        cmd_next;
    logic [TW-1:0] top_reg;
    logic [TW-1:0] top_next;
    logic [TW-1:0] top_m1;
    logic [2:0]  stack_mem [STACK_DEPTH];
    op_code_t    top_code;
    logic        nonempty;
    logic        full;
    logic        push_en;
    op_code_t    push_code;

    logic        adv;
    logic        gen_en;
    logic [7:0]  gen_byte;
    logic        fin;

    logic        out_valid_reg;
    logic        out_valid_next;
    logic [7:0]  out_byte_reg;
    logic [7:0]  out_byte_next;
    logic        out_last_reg;
    logic        out_last_next;
    logic        hold_valid_reg;
    logic        hold_valid_next;
    logic [7:0]  hold_byte_reg;
    logic [7:0]  hold_byte_next;

    assign top_m1   = top_reg - 1'b1;
    assign top_code = op_code_t'(stack_mem[top_m1[IW-1:0]]);
    assign nonempty = top_reg != '0;
    assign full     = top_reg == TW'(STACK_DEPTH);
    assign adv      = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        top_next   = top_reg;
        push_en    = 1'b0;
        push_code  = cmd_reg.code;
        gen_en     = 1'b0;
        gen_byte   = CH_SPACE;
        fin        = 1'b0;
        cmd_pop    = 1'b0;
        if (adv) begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (cmd_valid) begin
                        cmd_pop    = 1'b1;
                        cmd_next   = cmd;
                        state_next = ST_LEAD;
                    end
                end
                ST_LEAD:
                begin
                    gen_en     = cmd_reg.close_tok;
                    state_next = ST_EXEC;
                end
                ST_SPACE:
                begin
                    gen_en     = 1'b1;
                    state_next = ST_EXEC;
                end
                ST_DONE:
                begin
                    fin        = 1'b1;
                    state_next = ST_IDLE;
                end
                ST_EXEC:
                begin
                    state_next = ST_DONE;
                    unique case (cmd_reg.kind)
                        CMD_NONE:
                        begin
                        end
                        CMD_ECHO:
                        begin
                            gen_en   = 1'b1;
                            gen_byte = cmd_reg.ch;
                        end
                        CMD_OPEN:
                        begin
                            push_code = OPC_LPAREN;
                            push_en   = !full;
                        end
                        CMD_CLOSE:
                        begin
                            if (nonempty && (top_code != OPC_LPAREN)) begin
                                gen_en     = 1'b1;
                                gen_byte   = code_char(top_code);
                                top_next   = top_m1;
                                state_next = ST_SPACE;
                            end else if (nonempty) begin
                                top_next = top_m1;
                            end
                        end
                        CMD_OP:
                        begin
                            if (nonempty && (top_code != OPC_LPAREN) &&
                                (op_rank(top_code) >= op_rank(cmd_reg.code))) begin
                                gen_en     = 1'b1;
                                gen_byte   = code_char(top_code);
                                top_next   = top_m1;
                                state_next = ST_SPACE;
                            end else begin
                                push_en = !full;
                            end
                        end
                        CMD_FLUSH:
                        begin
                            if (nonempty) begin
                                top_next   = top_m1;
                                state_next = ST_EXEC;
                                if (top_code != OPC_LPAREN) begin
                                    gen_en     = 1'b1;
                                    gen_byte   = code_char(top_code);
                                    state_next = ST_SPACE;
                                end
                            end else begin
                                gen_en   = 1'b1;
                                gen_byte = CH_NL;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                default:
                begin
                    state_next = ST_IDLE;
                end
            endcase
        end
        if (push_en) begin
            top_next = top_reg + 1'b1;
        end
    end

    // The newest byte waits in the hold register until the next byte or the end
    // of the transaction shows whether it is the last one of its run.
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_byte_next   = out_byte_reg;
        out_last_next   = out_last_reg;
        hold_valid_next = hold_valid_reg;
        hold_byte_next  = hold_byte_reg;
        if (adv) begin
            out_valid_next = 1'b0;
            if (gen_en) begin
                if (hold_valid_reg) begin
                    out_valid_next = 1'b1;
                    out_byte_next  = hold_byte_reg;
                    out_last_next  = 1'b0;
                end
                hold_valid_next = 1'b1;
                hold_byte_next  = gen_byte;
            end else if (fin && hold_valid_reg) begin
                out_valid_next  = 1'b1;
                out_byte_next   = hold_byte_reg;
                out_last_next   = 1'b1;
                hold_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        out_byte_reg  <= out_byte_next;
        out_last_reg  <= out_last_next;
        hold_byte_reg <= hold_byte_next;
        if (push_en) begin
            stack_mem[top_reg[IW-1:0]] <= push_code;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg      <= ST_IDLE;
            top_reg        <= '0;
            out_valid_reg  <= 1'b0;
            hold_valid_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            top_reg        <= top_next;
            out_valid_reg  <= out_valid_next;
            hold_valid_reg <= hold_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;

endmodule

// ===== src/infix_to_postfix_converter.sv =====
// Converts an infix expression, one ASCII character per input transaction, into postfix
// text by the shunting-yard rule. The front end takes one character per cycle into a
// four-entry command queue unless it is full, so input bursts are absorbed; the back
// end's sequencer steps through each command, adding a space step for every operator it
// pops and another execute step for every '(' discarded by a flush. An input
// transaction that neither produces output nor touches the operator stack (whitespace,
// stray bytes) is dropped in the front end and costs the back end nothing.
// The output stream marks the final byte caused by each input transaction with tlast.
module infix_to_postfix_converter
    import icp_pkg::*;
#(
    parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // in_byte [7:0]
    input  logic       s_axis_tlast,   // end_of_expr
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // out_byte [7:0]
    output logic       m_axis_tlast    // last_of_run
);

    logic q_full;
    logic accept;
    logic wr_en;
    cmd_t wr_cmd;
    logic rd_valid;
    logic rd_en;
    cmd_t rd_cmd;

    assign s_axis_tready = !q_full;
    assign accept        = s_axis_tvalid && s_axis_tready;

    icp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_byte   (s_axis_tdata),
        .in_end    (s_axis_tlast),
        .accept    (accept),
        .cmd_valid (wr_en),
        .cmd       (wr_cmd)
    );

    icp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_cmd   (wr_cmd),
        .full     (q_full),
        .rd_valid (rd_valid),
        .rd_en    (rd_en),
        .rd_cmd   (rd_cmd)
    );

    icp_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (rd_valid),
        .cmd       (rd_cmd),
        .cmd_pop   (rd_en),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_byte  (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

endmodule

// ===== src/icp_checker.sv =====
module icp_checker
    import icp_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tlast
);

    logic op_out;

    assign op_out = m_axis_tvalid && ((m_axis_tdata == CH_PLUS) || (m_axis_tdata == CH_MINUS) ||
                    (m_axis_tdata == CH_STAR) || (m_axis_tdata == CH_SLASH));

    // A stalled output transaction keeps its byte and its end mark.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output transaction changed while stalled");

    // A newline only ever closes a flush.
    a_nl_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata == CH_NL) |-> m_axis_tlast)
        else $error("newline not marked as last of run");

    // Every popped operator is followed by its space.
    a_op_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        op_out |-> !m_axis_tlast)
        else $error("operator marked as last of run");

    // Opening parentheses are never written to the postfix text.
    a_no_lparen: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata != CH_LPAREN))
        else $error("opening parenthesis emitted");

endmodule

bind infix_to_postfix_converter icp_checker u_checker (.*);
